// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the box blur block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define BB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define BB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bblur_pkg.sv =====
// Types, constants and the reciprocal table of the 3x3 box blur.
`timescale 1ns / 1ps

package bblur_pkg;

  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int WIN_N       = 9;
  localparam int SUM_W       = 12;
  localparam int NUM_W       = 4;
  localparam int X_W         = SUM_W + 1;
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 18;
  localparam int PROD_W      = X_W + RECIP_W;

  localparam int CFG_DIM_W   = 11;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 11'd480;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = 3;
  localparam int QCNT_W      = 4;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef pixel_t [WIN_N-1:0] grid_t;

  typedef struct packed {
    logic            kind;
    logic [CH_W-1:0] pixel_red;
    logic [CH_W-1:0] pixel_green;
    logic [CH_W-1:0] pixel_blue;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] blurred_red;
    logic [CH_W-1:0] blurred_green;
    logic [CH_W-1:0] blurred_blue;
    logic            last_of_run;
    logic            last_of_frame;
  } out_t;

  // One neighbourhood to be averaged: entry 3*row+column, with a mask of the
  // entries that lie inside the image.
  typedef struct packed {
    grid_t            grid;
    logic [WIN_N-1:0] mask;
    logic             last_of_run;
    logic             last_of_frame;
  } job_t;

  typedef enum logic [1:0] {
    ST_PIXEL,
    ST_PRIME,
    ST_DRAIN
  } blur_state_t;

  // ceil(2^18 / (2n)); with it floor(x * m / 2^18) equals floor(x / (2n))
  // exactly for every x up to 2*9*255 + 9.
  function automatic logic [RECIP_W-1:0] mean_recip(input logic [NUM_W-1:0] n);
    logic [RECIP_W-1:0] m;
    unique case (n)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd5:    m = 18'd26215;
      4'd6:    m = 18'd21846;
      4'd7:    m = 18'd18725;
      4'd8:    m = 18'd16384;
      4'd9:    m = 18'd14564;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== design/bblur_line_store.sv =====
// Line store memory: one write port, one registered read port with write forwarding.
`timescale 1ns / 1ps

module bblur_line_store #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read of the entry being written returns the new data.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/bblur_window.sv =====
// Position control, 3x3 window and line store read-modify-write of the box blur.
`timescale 1ns / 1ps

module bblur_window #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  input  bblur_pkg::in_t                    item,
  output logic                              item_take,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    width_eff,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   height_eff,
  input  logic                              restart,
  input  logic                              job_space,
  output logic                              job_go,
  output bblur_pkg::job_t                   job
);
  import bblur_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  blur_state_t      state, state_next;
  logic [WW-1:0]    col, col_next;
  logic [WW-1:0]    drain_pos, drain_next;
  logic [HW-1:0]    row, row_next;
  grid_t            win, win_next;
  logic             pend_a, pend_a_next;
  logic             pend_b, pend_b_next;
  logic [WIN_N-1:0] mask_a, mask_a_next;
  logic [WIN_N-1:0] mask_b, mask_b_next;
  logic             pend_lof, pend_lof_next;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [2*PIX_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [2*PIX_W-1:0] mem_rdata;

  logic             window_free;
  logic             accept;

  // Entry c holds the older row in its upper half and the newer row below.
  bblur_line_store #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * PIX_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  function automatic grid_t shift_in(input grid_t g, input pixel_t top,
                                     input pixel_t mid, input pixel_t bot);
    grid_t s;
    s = g;
    for (int i = 0; i < 3; i++) begin
      s[3*i]   = g[3*i+1];
      s[3*i+1] = g[3*i+2];
    end
    s[2] = top;
    s[5] = mid;
    s[8] = bot;
    return s;
  endfunction

  function automatic logic [WIN_N-1:0] mask_of(input logic [2:0] rv,
                                                input logic [2:0] cv);
    logic [WIN_N-1:0] m;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[3*i+j] = rv[i] & cv[j];
      end
    end
    return m;
  endfunction

  always_comb begin
    pixel_t        px;
    pixel_t        fresh_old;
    pixel_t        fresh_new;
    logic          last_col;
    logic          last_row;
    logic          drain_end;
    logic [2:0]    rv;
    logic [WW-1:0] drain_ahead;

    px        = {item.pixel_red, item.pixel_green, item.pixel_blue};
    fresh_old = mem_rdata[2*PIX_W-1:PIX_W];
    fresh_new = mem_rdata[PIX_W-1:0];
    last_col  = (col + WW'(1)) >= width_eff;
    last_row  = (row + HW'(1)) >= height_eff;
    drain_end = (drain_pos + WW'(1)) >= width_eff;
    rv        = '0;

    state_next    = state;
    col_next      = col;
    row_next      = row;
    drain_next    = drain_pos;
    win_next      = win;
    pend_a_next   = pend_a;
    pend_b_next   = pend_b;
    mask_a_next   = mask_a;
    mask_b_next   = mask_b;
    pend_lof_next = pend_lof;

    mem_we    = 1'b0;
    mem_waddr = col[AW-1:0];
    mem_wdata = {fresh_new, px};

    // The main neighbourhood goes first; the extra right-edge one follows.
    if (pend_a) begin
      job.grid          = win;
      job.mask          = mask_a;
      job.last_of_run   = !pend_b;
      job.last_of_frame = pend_lof;
    end else begin
      job.grid          = shift_in(win, '0, '0, '0);
      job.mask          = mask_b;
      job.last_of_run   = 1'b1;
      job.last_of_frame = 1'b0;
    end
    job_go = (pend_a || pend_b) && job_space;

    // The window may change once every pending neighbourhood has been taken.
    window_free = !(pend_a || pend_b) || (job_go && !(pend_a && pend_b));
    item_take   = window_free && (state != ST_PRIME);
    accept      = item_valid && item_take;

    if (job_go) begin
      if (pend_a) begin
        pend_a_next = 1'b0;
      end else begin
        pend_b_next = 1'b0;
      end
    end

    unique case (state)
      ST_PIXEL: begin
        if (accept && (item.kind == KIND_PIXEL)) begin
          win_next  = shift_in(win, fresh_old, fresh_new, px);
          mem_we    = 1'b1;
          rv        = {1'b1, 1'b1, row > HW'(1)};
          pend_a_next   = (row != '0) && (col != '0);
          mask_a_next   = mask_of(rv, {1'b1, 1'b1, col > WW'(1)});
          pend_b_next   = (row != '0) && last_col;
          mask_b_next   = mask_of(rv, {1'b0, 1'b1, col != '0});
          pend_lof_next = 1'b0;
          if (last_col) begin
            col_next = '0;
            if (last_row) begin
              state_next = ST_PRIME;
              drain_next = '0;
            end else begin
              row_next = row + HW'(1);
            end
          end else begin
            col_next = col + WW'(1);
          end
        end
      end
      ST_PRIME: begin
        // Load the first column of the last two rows ahead of the drain.
        if (window_free) begin
          win_next   = shift_in(win, fresh_old, fresh_new, '0);
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (accept && (item.kind == KIND_DRAIN)) begin
          win_next      = shift_in(win, fresh_old, fresh_new, '0);
          rv            = {1'b0, 1'b1, height_eff > HW'(1)};
          pend_a_next   = 1'b1;
          mask_a_next   = mask_of(rv, {!drain_end, 1'b1, drain_pos != '0});
          pend_lof_next = drain_end;
          if (drain_end) begin
            state_next = ST_PIXEL;
            col_next   = '0;
            row_next   = '0;
            drain_next = '0;
          end else begin
            drain_next = drain_pos + WW'(1);
          end
        end
      end
      default: begin
        state_next = ST_PIXEL;
      end
    endcase

    if (restart) begin
      state_next = ST_PIXEL;
      col_next   = '0;
      row_next   = '0;
      drain_next = '0;
    end

    // Always fetch the entry that the next item will need.
    drain_ahead = drain_next + WW'(1);
    unique case (state_next)
      ST_PIXEL: mem_raddr = col_next[AW-1:0];
      ST_PRIME: mem_raddr = '0;
      ST_DRAIN: mem_raddr = drain_ahead[AW-1:0];
      default:  mem_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_PIXEL;
      col       <= '0;
      row       <= '0;
      drain_pos <= '0;
      pend_a    <= 1'b0;
      pend_b    <= 1'b0;
    end else begin
      state     <= state_next;
      col       <= col_next;
      row       <= row_next;
      drain_pos <= drain_next;
      pend_a    <= pend_a_next;
      pend_b    <= pend_b_next;
    end
  end

  always_ff @(posedge clk) begin
    win      <= win_next;
    mask_a   <= mask_a_next;
    mask_b   <= mask_b_next;
    pend_lof <= pend_lof_next;
  end

endmodule

// ===== design/bblur_mean.sv =====
// Two-stage rounded mean: masked channel sums, then a reciprocal multiply.
`timescale 1ns / 1ps

module bblur_mean (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_go,
  input  bblur_pkg::job_t  job,
  output logic             result_valid,
  output bblur_pkg::out_t  result,
  output logic [1:0]       fill
);
  import bblur_pkg::*;

  logic                       v1;
  logic [2:0][SUM_W-1:0]      sum1, sum_c;
  logic [NUM_W-1:0]           n1, n_c;
  logic                       lor1, lof1;
  logic                       v2;
  out_t                       res2;
  logic [2:0][CH_W-1:0]       mean_c;

  always_comb begin
    sum_c = '0;
    n_c   = '0;
    for (int k = 0; k < WIN_N; k++) begin
      if (job.mask[k]) begin
        n_c = n_c + NUM_W'(1);
        for (int ch = 0; ch < 3; ch++) begin
          sum_c[ch] = sum_c[ch] + SUM_W'(job.grid[k][ch*CH_W +: CH_W]);
        end
      end
    end
  end

  // mean = floor((2*sum + n) / (2n)), i.e. rounded to nearest with ties up.
  always_comb begin
    logic [X_W-1:0]    x;
    logic [PROD_W-1:0] prod;
    logic [RECIP_W-1:0] recip;
    recip = mean_recip(n1);
    for (int ch = 0; ch < 3; ch++) begin
      x          = {sum1[ch], 1'b0} + X_W'(n1);
      prod       = PROD_W'(x) * PROD_W'(recip);
      mean_c[ch] = prod[RECIP_SHIFT +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= job_go;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    sum1 <= sum_c;
    n1   <= n_c;
    lor1 <= job.last_of_run;
    lof1 <= job.last_of_frame;
    res2.blurred_red   <= mean_c[2];
    res2.blurred_green <= mean_c[1];
    res2.blurred_blue  <= mean_c[0];
    res2.last_of_run   <= lor1;
    res2.last_of_frame <= lof1;
  end

  assign result_valid = v2;
  assign result       = res2;
  assign fill         = {1'b0, v1} + {1'b0, v2};

endmodule

// ===== design/bblur_queue.sv =====
// Small result queue between the mean pipeline and the output channel.
`timescale 1ns / 1ps

module bblur_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  bblur_pkg::out_t          push_data,
  input  logic                     pop,
  output logic                     head_valid,
  output bblur_pkg::out_t          head,
  output logic [bblur_pkg::QCNT_W-1:0] count
);
  import bblur_pkg::*;

  out_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

endmodule

// ===== design/box_blur_3x3_edge_clipped.sv =====
// Top level of the 3x3 edge-clipped box blur over a raster-order RGB stream.
//
// Pixels enter in raster order, one request per clock when not stalled. A pixel that
// releases two results (the end of a row below the first, in a row of more than one
// column) holds off the next request until both are taken, since they share the one
// mean pipeline. After the last pixel of the frame a prime state loads the first
// column of the last two rows from the line store, then each drain request releases
// one result of the bottom row. The line store is a single memory of MAX_WIDTH
// entries, each holding the two previous rows of one column, read ahead of the
// request that needs it; its contents are undefined after reset, and an entry that
// has never been written is never counted in a mean, so there is no clearing pass.
// The first result of a request passes the pending flag, the mean pipeline and the
// queue to the output, and a second one follows it. Results wait in an eight-entry
// queue while the output stalls, and requests stall once the queue and the pipeline
// together hold eight results. Writing either size register restarts the frame.
`timescale 1ns / 1ps

module box_blur_3x3_edge_clipped #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  bblur_pkg::in_t                    pixel,
  output logic                              result_valid,
  input  logic                              result_stall,
  output bblur_pkg::out_t                   result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bblur_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bblur_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bblur_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready
);
  import bblur_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CMW = (WW > CFG_DIM_W) ? WW : CFG_DIM_W;
  localparam int CMH = (HW > CFG_DIM_W) ? HW : CFG_DIM_W;

  logic [CFG_DIM_W-1:0] image_width;
  logic [CFG_DIM_W-1:0] image_height;
  logic                 cfg_write;
  logic [CMW-1:0]       width_ext;
  logic [CMH-1:0]       height_ext;
  logic [WW-1:0]        width_eff;
  logic [HW-1:0]        height_eff;

  logic                 item_take;
  logic                 job_space;
  logic                 job_go;
  job_t                 job;
  logic                 mean_valid;
  out_t                 mean_result;
  logic [1:0]           fill;
  logic [QCNT_W-1:0]    q_count;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_HEIGHT) begin
        image_height <= pwdata[CFG_DIM_W-1:0];
      end else begin
        image_width <= pwdata[CFG_DIM_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ?
                  APB_DATA_W'(image_height) : APB_DATA_W'(image_width);

  // A size of zero acts as one, and a size beyond the maximum as the maximum.
  assign width_ext  = CMW'(image_width);
  assign height_ext = CMH'(image_height);
  assign width_eff  = (width_ext == '0)              ? WW'(1) :
                      (width_ext > CMW'(MAX_WIDTH))  ? WW'(MAX_WIDTH) : WW'(width_ext);
  assign height_eff = (height_ext == '0)             ? HW'(1) :
                      (height_ext > CMH'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(height_ext);

  // Room is reserved in the queue for every result already in the pipeline.
  assign job_space = (q_count + QCNT_W'(fill)) < QCNT_W'(QUEUE_DEPTH);

  bblur_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .item_valid (pixel_valid),
    .item       (pixel),
    .item_take  (item_take),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .restart    (cfg_write),
    .job_space  (job_space),
    .job_go     (job_go),
    .job        (job)
  );

  bblur_mean u_mean (
    .clk          (clk),
    .rst          (rst),
    .job_go       (job_go),
    .job          (job),
    .result_valid (mean_valid),
    .result       (mean_result),
    .fill         (fill)
  );

  bblur_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (mean_valid),
    .push_data  (mean_result),
    .pop        (result_valid && !result_stall),
    .head_valid (result_valid),
    .head       (result),
    .count      (q_count)
  );

  assign pixel_stall = !item_take;

endmodule

// ===== design/bblur_checker.sv =====
// Port-level checker of the box blur, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bblur_checker (
  input logic            clk,
  input logic            rst,
  input logic            result_valid,
  input logic            result_stall,
  input bblur_pkg::out_t result,
  input logic            pready
);
  import bblur_pkg::*;

  `BB_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid, "stalled result dropped")
  `BB_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(result), "stalled result changed")
  `BB_ASSERT_NOW(a_frame_end_single, result_valid && result.last_of_frame, result.last_of_run, "frame end result not last of its request")
  `BB_ASSERT_NOW(a_empty_after_reset, $past(rst), !result_valid, "result shown straight after reset")
  `BB_ASSERT_NOW(a_pready_high, 1'b1, pready, "configuration port not ready")

endmodule

bind box_blur_3x3_edge_clipped bblur_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .pready       (pready)
);
